// ----- rtl/cpc_pkg.sv -----
// Shared constants, types and helper functions for the contrast pixel counter.
package cpc_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int SIZE_W     = 10;
  localparam int TOTAL_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int OUT_DATA_W = ((TOTAL_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_LINE_WIDTH = 2'd1,
    REG_LINE_COUNT = 2'd2
  } cfg_reg_t;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET  = 8'd128;
  localparam logic [SIZE_W-1:0] LINE_WIDTH_RESET = 10'd320;
  localparam logic [SIZE_W-1:0] LINE_COUNT_RESET = 10'd200;

  // stage-1 request to the line store
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
    logic             clamped;
  } line_wr_t;

  // stage-1 update to the mark store
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] col;
    logic             cur;
    logic             left_set;
  } mark_upd_t;

  // last valid index of a saturated frame dimension
  function automatic int unsigned size_last(logic [SIZE_W-1:0] v, int unsigned lim);
    int unsigned x;
    x = int'(v);
    if (x < 2) x = 2;
    if (x > lim) x = lim;
    return x - 1;
  endfunction

  function automatic logic exceeds(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                   logic [THR_W-1:0] thr);
    logic [PIX_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > thr;
  endfunction

endpackage

// ----- rtl/cpc_line_store.sv -----
// Pixel line store: latest pixel per column plus its value from before the current row.
module cpc_line_store import cpc_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  line_wr_t         wr,
  output logic [PIX_W-1:0] above
);

  logic [PIX_W-1:0] cur_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] prev_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_cur;
  logic [PIX_W-1:0] rd_prev;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_cur  <= cur_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
    end
  end

  // first write of a column in a row saves the row-start value
  always_ff @(posedge clk) begin
    if (wr.en) begin
      cur_mem[wr.col] <= wr.pix;
      if (!wr.clamped) begin
        prev_mem[wr.col] <= rd_cur;
      end
    end
  end

  // a clamped column was already rewritten in this row
  assign above = wr.clamped ? rd_prev : rd_cur;

endmodule

// ----- rtl/cpc_mark_store.sv -----
// Counted-mark store with a one-entry write-back hold and read forwarding.
module cpc_mark_store import cpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_up_addr,
  input  logic [COL_W-1:0] rd_left_addr,
  input  mark_upd_t        upd,
  input  logic [COL_W-1:0] s1_col,
  output logic             up_mark,
  output logic             left_mark
);

  logic             mem [MAX_WIDTH];
  logic             rd_up;
  logic             rd_left;

  logic             hold_valid;
  logic             hold_dirty;
  logic [COL_W-1:0] hold_addr;
  logic             hold_val;

  logic [COL_W-1:0] left_col;
  logic             hit_left;
  logic             direct;
  logic             merge_set;
  logic             commit;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  logic             wr_data;

  assign left_col  = COL_W'(upd.col - 1'b1);
  assign hit_left  = hold_valid && (hold_addr == left_col);
  assign direct    = upd.en && upd.left_set && !hit_left;
  assign merge_set = upd.en && upd.left_set && hit_left;
  assign commit    = !direct && (hold_dirty || merge_set);

  always_comb begin
    wr_en   = direct || commit;
    wr_addr = direct ? left_col : hold_addr;
    wr_data = direct ? 1'b1 : (hold_val | merge_set);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_up   <= (wr_en && wr_addr == rd_up_addr) ? wr_data : mem[rd_up_addr];
      rd_left <= (wr_en && wr_addr == rd_left_addr) ? wr_data : mem[rd_left_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_dirty <= 1'b0;
    end else if (upd.en) begin
      hold_valid <= 1'b1;
      hold_dirty <= 1'b1;
    end else if (commit) begin
      hold_dirty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en) begin
      hold_addr <= upd.col;
      hold_val  <= upd.cur;
    end
  end

  assign up_mark   = (hold_valid && hold_addr == s1_col) ? hold_val : rd_up;
  assign left_mark = (hold_valid && hold_addr == COL_W'(s1_col - 1'b1)) ? hold_val : rd_left;

  // direct write only happens on the first pixel after a resize, with the hold flushed
  a_direct_clean: assert property (@(posedge clk) disable iff (rst)
    direct |-> !hold_dirty)
    else $error("mark hold dirty on direct write");

  a_dirty_flush: assert property (@(posedge clk) disable iff (rst)
    hold_dirty && !upd.en |=> !hold_dirty || upd.en || $past(direct))
    else $error("mark hold not flushed");

endmodule

// ----- rtl/contrast_pixel_counter_core.sv -----
// Top level of the contrast pixel counter: scan position, compare stage, frame total.
//
//  channel | dir | beat fields
//  s_*     | in  | tdata[7:0] pixel_value
//  m_*     | out | tdata[18:0] contrast_total (zero padded to 24)
//  cfg_*   | in  | cfg_index register, cfg_data value (always ready)
//
//  One pixel per clock while s_tready is high; the core first reads the line and mark
//  stores, then compares and writes back on the registered read data.
//  A frame total is registered for output when the frame's last pixel fires in the compare stage.
//  Synchronous active-high reset clears control state; stores are not cleared.
//  s_tready drops only while a frame total waits in a full output register.
module contrast_pixel_counter_core import cpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,     // [7:0] pixel_value
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,     // [18:0] contrast_total
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [THR_W-1:0]   threshold;
  logic [COL_W-1:0]   width_last;
  logic [ROW_W-1:0]   height_last;

  logic [COL_W-1:0]   column_position;
  logic [ROW_W-1:0]   row_position;
  logic [PIX_W-1:0]   left_neighbour;
  logic [TOTAL_W-1:0] running_total;

  logic               acc;
  logic               col_over;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic               last_col;
  logic               last_row;

  logic               s1_valid;
  logic               s1_fire;
  logic [COL_W-1:0]   s1_col;
  logic               s1_row_nz;
  logic               s1_clamped;
  logic               s1_end;
  logic [PIX_W-1:0]   s1_pix;
  logic [PIX_W-1:0]   s1_left;

  logic [PIX_W-1:0]   above;
  logic               up_mark;
  logic               left_mark;
  logic               left_hit;
  logic               up_hit;
  logic               cur;
  logic [1:0]         inc;
  logic [TOTAL_W-1:0] total_sum;

  logic               out_valid;
  logic [TOTAL_W-1:0] out_total;

  line_wr_t           line_wr;
  mark_upd_t          mark_upd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THRESHOLD_RESET;
      width_last  <= COL_W'(size_last(LINE_WIDTH_RESET, MAX_WIDTH));
      height_last <= ROW_W'(size_last(LINE_COUNT_RESET, MAX_HEIGHT));
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD:  threshold   <= cfg_data[THR_W-1:0];
        REG_LINE_WIDTH: width_last  <= COL_W'(size_last(cfg_data, MAX_WIDTH));
        REG_LINE_COUNT: height_last <= ROW_W'(size_last(cfg_data, MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // stage 0: position and store reads
  assign acc      = s_tvalid && s_tready;
  assign col_over = column_position > width_last;
  assign col      = col_over ? width_last : column_position;
  assign row      = (row_position > height_last) ? height_last : row_position;
  assign last_col = col == width_last;
  assign last_row = row == height_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      left_neighbour  <= '0;
    end else if (acc) begin
      left_neighbour <= s_tdata;
      if (!last_col) begin
        column_position <= COL_W'(col + 1'b1);
        row_position    <= row;
      end else begin
        column_position <= '0;
        row_position    <= last_row ? '0 : ROW_W'(row + 1'b1);
      end
    end
  end

  assign s1_fire  = s1_valid && !(s1_end && out_valid);
  assign s_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col     <= col;
      s1_row_nz  <= row != '0;
      s1_clamped <= col_over;
      s1_end     <= last_col && last_row;
      s1_pix     <= s_tdata;
      s1_left    <= left_neighbour;
    end
  end

  always_comb begin
    line_wr.en      = s1_fire;
    line_wr.col     = s1_col;
    line_wr.pix     = s1_pix;
    line_wr.clamped = s1_clamped;
  end

  cpc_line_store u_line_store (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (col),
    .wr      (line_wr),
    .above   (above)
  );

  // stage 1: compare, count, write back
  assign left_hit  = (s1_col != '0) && exceeds(s1_pix, s1_left, threshold);
  assign up_hit    = s1_row_nz && exceeds(s1_pix, above, threshold);
  assign cur       = left_hit || up_hit;
  assign inc       = {1'b0, left_hit && !left_mark} + {1'b0, up_hit && !up_mark}
                   + {1'b0, cur};
  assign total_sum = TOTAL_W'(running_total + TOTAL_W'(inc));

  always_comb begin
    mark_upd.en       = s1_fire;
    mark_upd.col      = s1_col;
    mark_upd.cur      = cur;
    mark_upd.left_set = left_hit && !left_mark;
  end

  cpc_mark_store u_mark_store (
    .clk          (clk),
    .rst          (rst),
    .rd_en        (acc),
    .rd_up_addr   (col),
    .rd_left_addr (COL_W'(col - 1'b1)),
    .upd          (mark_upd),
    .s1_col       (s1_col),
    .up_mark      (up_mark),
    .left_mark    (left_mark)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (s1_fire) begin
        running_total <= s1_end ? '0 : total_sum;
      end
      if (s1_fire && s1_end) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_end) begin
      out_total <= total_sum;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'(out_total);

  a_end_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_end && out_valid |-> !s_tready)
    else $error("frame end overran output register");

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    acc && last_col |=> column_position == '0)
    else $error("column did not wrap at row end");

  a_total_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_end |=> m_tvalid && running_total == '0)
    else $error("frame total not presented");

endmodule
